// File: hdl/quotient_filter_count_encoder_top_macros.svh
// Assertion macros shared by the counter encoder RTL.
`ifndef QUOTIENT_FILTER_COUNT_ENCODER_TOP_MACROS_SVH
`define QUOTIENT_FILTER_COUNT_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define QFCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define QFCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/qfce_pkg.sv
// Types and constants shared by the counter encoder modules.
`timescale 1ns / 1ps

package qfce_pkg;

  localparam int CNT_W     = 32;             // occurrence count and dividend width
  localparam int SLOT_W    = 32;             // slot value field width
  localparam int DIVISOR_W = 33;             // full digit clipped to 2^33-1
  localparam int RB_W      = 6;              // remainder_bits register width

  localparam logic [RB_W-1:0] RB_RESET = 6'd8;
  localparam logic [RB_W-1:0] RB_MIN   = 6'd2;
  localparam logic [RB_W-1:0] RB_CLIP  = 6'd33;

  // register index taken from the word address
  localparam logic REG_REMAINDER_BITS = 1'b0;

  typedef struct packed {
    logic                 start;
    logic [CNT_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } qfce_div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [CNT_W-1:0]     quot;
    logic [DIVISOR_W-1:0] rmd;
  } qfce_div_res_t;

endpackage

// File: hdl/qfce_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module qfce_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  qfce_pkg::qfce_div_req_t req,
  output qfce_pkg::qfce_div_res_t res
);

  localparam int STEP_W = $clog2(qfce_pkg::CNT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(qfce_pkg::CNT_W - 1);

  logic [qfce_pkg::DIVISOR_W-1:0] p_r, p_nxt, d_r;
  logic [qfce_pkg::CNT_W-1:0]     q_r;
  logic [STEP_W-1:0]              step_r;
  logic                           busy_r, done_r;
  logic [qfce_pkg::DIVISOR_W:0]   trial, diff;
  logic                           fits;

  always_comb begin
    // shift the next dividend bit into the partial remainder
    trial = {p_r, q_r[qfce_pkg::CNT_W-1]};
    diff  = trial - {1'b0, d_r};
    fits  = (trial >= {1'b0, d_r});
    p_nxt = fits ? diff[qfce_pkg::DIVISOR_W-1:0] : trial[qfce_pkg::DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !req.start && (step_r == LAST_STEP);
      if (req.start) begin
        p_r    <= '0;
        q_r    <= req.dividend;
        d_r    <= req.divisor;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        p_r    <= p_nxt;
        q_r    <= {q_r[qfce_pkg::CNT_W-2:0], fits};
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.quot = q_r;
  assign res.rmd  = p_r;

endmodule

// File: hdl/quotient_filter_count_encoder_top.sv
// Counting quotient filter counter encoder: turns (remainder, count) into slot values.
// Flow: an item with count 1 passes through the check and emit states to the output register; a larger
//   count first waits in the divide state for the 32-step bit-serial divider to finish.
// Throughput: one slot per cycle once emitting, while out_tready holds; an item holds the
//   block until its last slot is loaded, and the next input is taken only after that slot.
// Reset: synchronous active-low rst_n idles the sequencer and sets remainder_bits to 8.
`timescale 1ns / 1ps
`include "quotient_filter_count_encoder_top_macros.svh"

module quotient_filter_count_encoder_top #(
  parameter int MAX_RUN        = 64,
  parameter int SLOT_WIDTH_MAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [31:0] remainder_value, [63:32] occurrences
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // out_tdata: [31:0] slot_value; out_tlast: is_last; out_tuser: [0] too_long
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int POS_W    = $clog2(MAX_RUN + 1);
  localparam int SWM_CLIP = (SLOT_WIDTH_MAX > 63) ? 63 : SLOT_WIDTH_MAX;
  localparam logic [qfce_pkg::RB_W-1:0] SWM_L = qfce_pkg::RB_W'(SWM_CLIP);
  localparam logic [qfce_pkg::CNT_W+1:0] MAX_RUN_L = (qfce_pkg::CNT_W + 2)'(MAX_RUN);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_CHECK, S_EMIT} state_t;

  state_t                          state_r;
  logic [qfce_pkg::RB_W-1:0]       rb_r, r_eff, r_div;
  logic [qfce_pkg::DIVISOR_W-1:0]  full33;
  logic [qfce_pkg::SLOT_W-1:0]     rem_in, rem_r, full_r, digits_r, left_r, left_w, slot_w;
  logic [qfce_pkg::CNT_W-1:0]      cnt_in, extra_in;
  logic                            rem_zero_r, cnt_one_r, escape_r, too_long_r;
  logic [POS_W:0]                  head_r, hd_end_r, head_w;
  logic [POS_W-1:0]                len_r, pos_r;
  logic [qfce_pkg::CNT_W+1:0]      len_w;
  logic                            in_xfer, cfg_wr, pos_last, emit_go;
  logic                            out_tvalid_r, out_last_r, out_flag_r;
  logic [qfce_pkg::SLOT_W-1:0]     out_data_r;
  qfce_pkg::qfce_div_req_t         div_req;
  qfce_pkg::qfce_div_res_t         div_res;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite
                      & (cfg_paddr[2] == qfce_pkg::REG_REMAINDER_BITS);
  assign cfg_prdata = (cfg_paddr[2] == qfce_pkg::REG_REMAINDER_BITS)
                      ? {{(32 - qfce_pkg::RB_W){1'b0}}, rb_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r <= qfce_pkg::RB_RESET;
    end else if (cfg_wr) begin
      rb_r <= cfg_pwdata[qfce_pkg::RB_W-1:0];
    end
  end

  always_comb begin
    r_eff = rb_r;
    if (r_eff < qfce_pkg::RB_MIN) r_eff = qfce_pkg::RB_MIN;
    if (r_eff > SWM_L)            r_eff = SWM_L;
    // any digit wider than 33 bits exceeds every count, so clip there
    r_div  = (r_eff > qfce_pkg::RB_CLIP) ? qfce_pkg::RB_CLIP : r_eff;
    full33 = ~({qfce_pkg::DIVISOR_W{1'b1}} << r_div);
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign rem_in    = in_tdata[31:0] & full33[qfce_pkg::SLOT_W-1:0];
  assign cnt_in    = in_tdata[63:32];
  assign extra_in  = cnt_in - 32'd2;

  always_comb begin
    div_req.start    = in_xfer && (cnt_in > 32'd1);
    div_req.dividend = extra_in;
    div_req.divisor  = (rem_in == '0) ? full33 : (full33 - 1'b1);
  end

  qfce_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .res  (div_res)
  );

  always_comb begin
    left_w = div_res.rmd[qfce_pkg::SLOT_W-1:0];
    // bump the leftover digit past the remainder so it cannot be read as the close
    if (!rem_zero_r && (left_w != '0) && (left_w >= rem_r)) left_w = left_w + 1'b1;

    if (cnt_one_r) begin
      len_w = (qfce_pkg::CNT_W + 2)'(1);
    end else begin
      len_w = (rem_zero_r ? (qfce_pkg::CNT_W + 2)'(3) : (qfce_pkg::CNT_W + 2)'(2))
              + (qfce_pkg::CNT_W + 2)'(escape_r)
              + (qfce_pkg::CNT_W + 2)'(digits_r)
              + (qfce_pkg::CNT_W + 2)'(left_r != '0);
    end
    head_w = (POS_W + 1)'(1) + (POS_W + 1)'(!cnt_one_r && rem_zero_r)
             + (POS_W + 1)'(escape_r);

    pos_last = (pos_r == len_r - 1'b1);
    if (pos_last || (pos_r == '0))    slot_w = rem_r;
    else if ({1'b0, pos_r} < head_r)  slot_w = '0;
    else if ({1'b0, pos_r} < hd_end_r) slot_w = full_r;
    else                              slot_w = left_r;
  end

  // load the output register when it is empty or being drained
  assign emit_go = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tready && !emit_go) out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            rem_r      <= rem_in;
            full_r     <= full33[qfce_pkg::SLOT_W-1:0];
            rem_zero_r <= (rem_in == '0);
            cnt_one_r  <= (cnt_in == 32'd1);
            escape_r   <= (cnt_in > 32'd1) && (rem_in != '0) && (extra_in >= rem_in);
            digits_r   <= '0;
            left_r     <= '0;
            if (cnt_in == 32'd1)     state_r <= S_CHECK;
            else if (cnt_in != '0)  state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            digits_r <= div_res.quot;
            left_r   <= left_w;
            state_r  <= S_CHECK;
          end
        end
        S_CHECK: begin
          too_long_r <= (len_w > MAX_RUN_L);
          len_r      <= len_w[POS_W-1:0];
          head_r     <= head_w;
          hd_end_r   <= head_w + digits_r[POS_W:0];
          pos_r      <= '0;
          state_r    <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_tvalid_r <= 1'b1;
            if (too_long_r) begin
              out_data_r <= '0;
              out_last_r <= 1'b1;
              out_flag_r <= 1'b1;
              state_r    <= S_IDLE;
            end else begin
              out_data_r <= slot_w;
              out_last_r <= pos_last;
              out_flag_r <= 1'b0;
              pos_r      <= pos_r + 1'b1;
              if (pos_last) state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_flag_r;

  `QFCE_ASSERT_IMP(a_flag_is_single, out_tvalid && out_tuser, out_tlast && (out_tdata == '0), "too_long result must be a lone zero slot")
  `QFCE_ASSERT_NXT(a_zero_count_idle, in_tvalid && in_tready && (in_tdata[63:32] == '0), in_tready, "zero count must leave the block idle")
  `QFCE_ASSERT_IMP(a_pos_in_run, (state_r == S_EMIT) && !too_long_r, pos_r < len_r, "slot position ran past the run length")
  `QFCE_ASSERT_IMP(a_div_idle, state_r == S_IDLE, !div_res.busy, "divider busy while sequencer idle")

endmodule

// File: tb/tb_quotient_filter_count_encoder_top.sv
// Self-checking testbench for the quotient filter counter encoder.
`timescale 1ns / 1ps

module tb_quotient_filter_count_encoder_top;

  localparam int RUN_LIMIT = 64;
  localparam int WIDTH_CAP = 32;
  localparam logic [2:0] RB_ADDR = {qfce_pkg::REG_REMAINDER_BITS, 2'b00};

  typedef struct packed {
    logic [31:0] value;
    logic        is_last;
    logic        too_long;
  } slot_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  slot_t                     expected_slots[$];
  logic [qfce_pkg::RB_W-1:0] width_reg = qfce_pkg::RB_RESET;
  int                        mismatches = 0;
  int unsigned               send_idle_pct = 0;
  int unsigned               recv_idle_pct = 0;
  logic                      hold_rx = 1'b0;

  quotient_filter_count_encoder_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  function automatic int unsigned eff_width(input logic [qfce_pkg::RB_W-1:0] w);
    if (w < 2) return 2;
    if (w > WIDTH_CAP) return WIDTH_CAP;
    return w;
  endfunction

  // Work out the slot run for one (remainder, count) pair and queue it.
  task automatic encode_run(input logic [31:0] rem_in, input logic [31:0] cnt_in);
    logic [63:0] full, rem, cnt, extra, digits, spill, dv, len, i;
    logic [63:0] run[$];
    bit          esc;
    slot_t       s;
    full = (64'd1 << eff_width(width_reg)) - 64'd1;
    rem = {32'd0, rem_in} & full;
    cnt = {32'd0, cnt_in};
    extra = cnt - 64'd2;
    digits = 0;
    spill = 0;
    esc = 1'b0;
    if (cnt == 0) return;
    if (cnt == 1) begin
      len = 1;
    end else if (rem == 0) begin
      digits = extra / full;
      spill = extra % full;
      len = 3 + digits + (spill != 0);
    end else if (cnt == 2) begin
      len = 2;
    end else begin
      dv = full - 1;
      digits = extra / dv;
      spill = extra % dv;
      esc = (extra >= rem);
      // bump the leftover digit past the remainder
      if (spill != 0 && spill >= rem) spill++;
      len = 2 + esc + digits + (spill != 0);
    end
    if (len > RUN_LIMIT) begin
      s = '{value: 32'd0, is_last: 1'b1, too_long: 1'b1};
      expected_slots.insert(expected_slots.size(), s);
      return;
    end
    run.insert(run.size(), rem);
    if (cnt > 1) begin
      if (rem == 0) run.insert(run.size(), 64'd0);
      if (esc) run.insert(run.size(), 64'd0);
      for (i = 0; i < digits; i++) run.insert(run.size(), full);
      if (spill != 0) run.insert(run.size(), spill);
      run.insert(run.size(), rem);
    end
    foreach (run[k]) begin
      s = '{value: run[k][31:0], is_last: (k == run.size() - 1), too_long: 1'b0};
      expected_slots.insert(expected_slots.size(), s);
    end
  endtask

  // Check every result transfer against the oldest queued slot.
  always @(posedge clk) begin
    slot_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_slots.size() == 0) begin
        log_mismatch($sformatf("unexpected slot %h last %b flag %b",
                               out_tdata, out_tlast, out_tuser));
      end else begin
        want = expected_slots[0];
        expected_slots.delete(0);
        if (out_tdata !== want.value || out_tlast !== want.is_last ||
            out_tuser !== want.too_long)
          log_mismatch($sformatf("slot exp %h/%b/%b got %h/%b/%b",
                                 want.value, want.is_last, want.too_long,
                                 out_tdata, out_tlast, out_tuser));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_rx) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic [31:0] rem, input logic [31:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {cnt, rem};
    do @(posedge clk); while (!in_tready);
    encode_run(rem, cnt);
  endtask

  // Drop valid, let the expected slots arrive, then allow for a count-0 item in flight.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic cfg_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= RB_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_width_reg();
    logic [31:0] rd;
    cfg_xfer(1'b0, 32'd0, rd);
    if (rd !== {26'd0, width_reg})
      log_mismatch($sformatf("remainder_bits read exp %0d got %h", width_reg, rd));
  endtask

  task automatic set_width(input logic [qfce_pkg::RB_W-1:0] w);
    logic [31:0] rd;
    drain();
    // upper bits of the write data are random and must be ignored
    cfg_xfer(1'b1, ($urandom & 32'hFFFF_FFC0) | {26'd0, w}, rd);
    width_reg = w;
    check_width_reg();
  endtask

  function automatic logic [qfce_pkg::RB_W-1:0] pick_width();
    case ($urandom_range(7))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd2;
      3: return 6'd32;
      4: return 6'd63;
      5: return 6'($urandom_range(33, 62));
      default: return 6'($urandom_range(3, 31));
    endcase
  endfunction

  // Mostly counts that give in-range runs near the digit and escape boundaries.
  function automatic logic [63:0] pick_item();
    logic [63:0] full, dv, reff, spill, cnt;
    logic [31:0] rem_in;
    int unsigned sel;
    full = (64'd1 << eff_width(width_reg)) - 64'd1;
    case ($urandom_range(9))
      0, 1: rem_in = $urandom & ~full[31:0];
      2: rem_in = full[31:0];
      3: rem_in = 32'd1;
      default: rem_in = $urandom;
    endcase
    reff = {32'd0, rem_in} & full;
    dv = (reff == 0) ? full : full - 1;
    sel = $urandom_range(99);
    if (sel < 5) begin
      cnt = 0;
    end else if (sel < 12) begin
      cnt = 1;
    end else if (sel < 18) begin
      cnt = 2;
    end else if (sel < 30) begin
      cnt = reff + $urandom_range(1, 3);
    end else if (sel < 85) begin
      case ($urandom_range(3))
        0: spill = 0;
        1: spill = (reff < dv) ? reff : 64'd0;
        default: spill = {$urandom, $urandom} % dv;
      endcase
      cnt = 64'd2 + $urandom_range(0, 66) * dv + spill;
    end else begin
      cnt = $urandom;
    end
    if (cnt > 64'hFFFF_FFFF) cnt = $urandom;
    return {cnt[31:0], rem_in};
  endfunction

  task automatic test_register_reset();
    check_width_reg();
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(32'd5, 32'd0);
    send_item(32'd5, 32'd1);
    send_item(32'd0, 32'd1);
    send_item(32'd0, 32'd2);
    send_item(32'd0, 32'd259);
    send_item(32'd0, 32'd257);
    send_item(32'd5, 32'd2);
    send_item(32'd5, 32'd6);
    send_item(32'd5, 32'd7);
    send_item(32'd3, 32'd5);
    send_item(32'd200, 32'd764);
    send_item(32'hFFFF_FF05, 32'd4);
    send_item(32'd0, 32'd15557);
    send_item(32'd0, 32'd15558);
    send_item(32'hFF, 32'hFFFF_FFFF);
    set_width(6'd63);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'd0, 32'hFFFF_FFFF);
    send_item(32'd1, 32'hFFFF_FFFF);
    set_width(6'd0);
    send_item(32'd3, 32'd2);
    send_item(32'd2, 32'd7);
    send_item(32'd1, 32'd5);
    set_width(6'd1);
    send_item(32'd0, 32'd9);
    set_width(6'd33);
    send_item(32'h8000_0000, 32'd3);
  endtask

  task automatic test_random(input int unsigned s_pct, input int unsigned r_pct,
                             input int n_items);
    logic [63:0] item;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (5) begin
      set_width(pick_width());
      repeat (n_items / 5) begin
        item = pick_item();
        send_item(item[31:0], item[63:32]);
      end
    end
  endtask

  // Hold the receiver off while long runs keep arriving, so the input stalls.
  task automatic test_backpressure();
    set_width(6'd4);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    repeat (8) send_item($urandom, 32'd2 + 32'd30 * 32'd14 + 32'($urandom_range(0, 13)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset();
    test_directed();
    test_random(33, 68, 70);
    test_random(68, 33, 70);
    test_random(0, 0, 60);
    test_backpressure();
    drain();
    if (mismatches == 0) begin
      $display("tb_quotient_filter_count_encoder_top: PASS");
    end else begin
      $display("tb_quotient_filter_count_encoder_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_quotient_filter_count_encoder_top: FAIL");
    $finish;
  end

endmodule
